### rtl/core/h2r_pkg.sv
// Shared types and constants for the HSV to RGB converter.
package h2r_pkg;

  // Field widths
  localparam int unsigned HueW  = 12;
  localparam int unsigned PctW  = 7;
  localparam int unsigned ChanW = 8;
  localparam int unsigned QuoW  = 13;   // floor(hue*5/3) for any 12-bit hue
  localparam int unsigned WW    = 18;   // signed channel weight, -27000..100000

  // Default depth of the queue between front and back
  localparam int unsigned H2R_QDEPTH = 4;

  // floor(n/3) == (n * 43691) >> 17 for n < 2^17
  localparam logic [15:0] DIV3_MUL = 16'd43691;
  localparam int unsigned DIV3_SHIFT = 17;

  // floor(n/78125) == (n * 56294996) >> 42 for n < 2^25
  localparam logic [25:0] DIV5P7_MUL = 26'd56294996;
  localparam int unsigned DIV5P7_SHIFT = 42;

  // Weight of the channel that carries the full chroma: s*1000 + 1000*(100-s)
  localparam logic signed [WW-1:0] W_FULL = 18'sd100000;

  // Hue sector: first name is the channel at full chroma, second the one at x
  typedef enum logic [2:0] {
    SEC_RED_GRN = 3'd0,   // hue below 600
    SEC_GRN_RED = 3'd1,   // 600..1199
    SEC_GRN_BLU = 3'd2,   // 1200..1799
    SEC_BLU_GRN = 3'd3,   // 1800..2399
    SEC_BLU_RED = 3'd4,   // 2400..2999
    SEC_RED_BLU = 3'd5    // 3000 and up
  } sector_e;

  // Classified word handed from front to back
  typedef struct packed {
    sector_e          sector;
    logic [QuoW-1:0]  quo;    // floor(hue*5/3)
    logic [PctW-1:0]  sat;
    logic [PctW-1:0]  val;
  } item_t;

endpackage

### rtl/core/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: front, queue and back pipeline.
//
//  channel   dir  handshake             tdata fields (low bit up)
//  s_axis    in   tvalid_i / tready_o   hue[11:0] sat[18:12] val[25:19] zero[31:26]
//  m_axis    out  tvalid_o / tready_i   red[7:0] green[15:8] blue[23:16]
//
// One word per cycle in and out when both sides keep up. A word passes one
// front register, the queue and four back stages: weights, the value
// multiply, the divide by 10^7 and the clamp.
// Reset clears all valid flags and the queue; there is no kept state.
// An output stall freezes the back pipeline; the queue then soaks up words
// from the front until full, and only then does s_axis_tready_o drop.
module hsv_to_rgb_converter #(
  parameter int unsigned QDepth = h2r_pkg::H2R_QDEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,    // hue[11:0], saturation[18:12], brightness[25:19]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o     // red[7:0], green[15:8], blue[23:16]
);
  import h2r_pkg::*;

  localparam int unsigned LvlW = $clog2(QDepth + 1);

  // front to queue
  logic            f_valid, f_ready;
  item_t           f_item;
  // queue to back
  logic            b_valid, b_ready;
  item_t           b_item;
  logic [LvlW-1:0] q_level;
  logic [ChanW-1:0] red, green, blue;

  // Classify: scaled hue and sector, one register deep
  h2r_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .hue_i       (s_axis_tdata_i[11:0]),
    .sat_i       (s_axis_tdata_i[18:12]),
    .val_i       (s_axis_tdata_i[25:19]),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_item_o  (f_item)
  );

  // Decouple: lets the front keep accepting while the back is stalled
  h2r_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item),
    .level_o      (q_level)
  );

  // Compute: per-channel weights, scale by value, divide, clamp
  h2r_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .in_item_i   (b_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_red_o   (red),
    .out_green_o (green),
    .out_blue_o  (blue)
  );

  assign m_axis_tdata_o = {blue, green, red};

  // Queue never takes a word while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid && f_ready) |-> (q_level != LvlW'(QDepth)))
    else $error("queue push while full");

  // Queue never hands out a word while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid && b_ready) |-> (q_level != '0))
    else $error("queue pop while empty");

  // Fill level tracks pushes and pops exactly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (q_level == LvlW'($past(q_level) + LvlW'($past(f_valid && f_ready))
                                - LvlW'($past(b_valid && b_ready)))))
    else $error("queue level out of step");

  // A stalled back pipeline pulls nothing from the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !b_ready)
    else $error("back pipeline advanced under stall");

endmodule

### rtl/core/h2r_front.sv
// Front stage: accept a word, find its hue sector and scaled hue.
module h2r_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [h2r_pkg::HueW-1:0]    hue_i,
  input  logic [h2r_pkg::PctW-1:0]    sat_i,
  input  logic [h2r_pkg::PctW-1:0]    val_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output h2r_pkg::item_t              out_item_o
);
  import h2r_pkg::*;

  logic        valid_q, valid_d;
  item_t       item_q, item_d;
  logic [14:0] hue5;
  logic [30:0] prod3;
  logic        take;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    hue5  = {hue_i, 2'b00} + {3'b000, hue_i};
    prod3 = {16'd0, hue5} * {15'd0, DIV3_MUL};

    item_d     = item_q;
    item_d.quo = prod3[DIV3_SHIFT +: QuoW];
    item_d.sat = sat_i;
    item_d.val = val_i;
    if (hue_i < 12'd600) begin
      item_d.sector = SEC_RED_GRN;
    end else if (hue_i < 12'd1200) begin
      item_d.sector = SEC_GRN_RED;
    end else if (hue_i < 12'd1800) begin
      item_d.sector = SEC_GRN_BLU;
    end else if (hue_i < 12'd2400) begin
      item_d.sector = SEC_BLU_GRN;
    end else if (hue_i < 12'd3000) begin
      item_d.sector = SEC_BLU_RED;
    end else begin
      item_d.sector = SEC_RED_BLU;
    end

    valid_d = take ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

### rtl/core/h2r_fifo.sv
// Short queue of classified words between front and back.
module h2r_fifo #(
  parameter int unsigned Depth = h2r_pkg::H2R_QDEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_valid_i,
  output logic                          push_ready_o,
  input  h2r_pkg::item_t                push_item_i,
  output logic                          pop_valid_o,
  input  logic                          pop_ready_i,
  output h2r_pkg::item_t                pop_item_o,
  output logic [$clog2(Depth+1)-1:0]    level_o
);
  import h2r_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LvlW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0] level_q, level_d;
  logic            push, pop;

  assign push_ready_o = (level_q != LvlW'(Depth));
  assign pop_valid_o  = (level_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign level_o      = level_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      level_d = level_q + 1'b1;
    end else if (pop && !push) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### rtl/core/h2r_back.sv
// Back pipeline: weights, scaling by value, divide by 10^7, clamp.
module h2r_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  h2r_pkg::item_t              in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [h2r_pkg::ChanW-1:0]   out_red_o,
  output logic [h2r_pkg::ChanW-1:0]   out_green_o,
  output logic [h2r_pkg::ChanW-1:0]   out_blue_o
);
  import h2r_pkg::*;

  localparam int unsigned PW = 26;   // signed v*w

  logic en;

  // stage 1: position in the 120-degree span, x and zero weights
  logic                   v1_q;
  sector_e                sec1_q;
  logic [PctW-1:0]        val1_q;
  logic signed [WW-1:0]   wx1_q, wz1_q;
  logic [12:0]            t_a;
  logic [10:0]            t_b;
  logic [9:0]             span_dist, kx;
  logic [16:0]            sx, s1000;
  logic signed [18:0]     m0_full, wx_full;

  // stage 2: v*w per channel
  logic                   v2_q;
  logic signed [PW-1:0]   p2_q [3];
  logic signed [WW-1:0]   wsel [3];
  logic signed [PW-1:0]   p_d [3];

  // stage 3: quotient by 10^7
  logic                   v3_q;
  logic                   neg3_q [3];
  logic [8:0]             quo3_q [3];
  logic [8:0]             quo_d [3];
  logic [23:0]            pn [3];
  logic [31:0]            n255 [3];
  logic [50:0]            prod [3];

  // stage 4: clamped output
  logic                   v4_q;
  logic [ChanW-1:0]       ch4_q [3];
  logic [ChanW-1:0]       ch_d [3];

  assign en          = !v4_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v4_q;
  assign out_red_o   = ch4_q[0];
  assign out_green_o = ch4_q[1];
  assign out_blue_o  = ch4_q[2];

  always_comb begin
    t_a       = (in_item_i.quo >= 13'd4000) ? in_item_i.quo - 13'd4000 : in_item_i.quo;
    t_b       = (t_a >= 13'd2000) ? 11'(t_a - 13'd2000) : t_a[10:0];
    span_dist = (t_b >= 11'd1000) ? 10'(t_b - 11'd1000) : 10'(11'd1000 - t_b);
    kx        = 10'd1000 - span_dist;
    sx        = {10'd0, in_item_i.sat} * {7'd0, kx};
    s1000     = {10'd0, in_item_i.sat} * 17'd1000;
    m0_full   = 19'sd100000 - $signed({2'b00, s1000});
    wx_full   = m0_full + $signed({2'b00, sx});
  end

  always_comb begin
    wsel[0] = wz1_q;
    wsel[1] = wz1_q;
    wsel[2] = wz1_q;
    unique case (sec1_q)
      SEC_RED_GRN: begin wsel[0] = W_FULL; wsel[1] = wx1_q;  end
      SEC_GRN_RED: begin wsel[0] = wx1_q;  wsel[1] = W_FULL; end
      SEC_GRN_BLU: begin wsel[1] = W_FULL; wsel[2] = wx1_q;  end
      SEC_BLU_GRN: begin wsel[1] = wx1_q;  wsel[2] = W_FULL; end
      SEC_BLU_RED: begin wsel[0] = wx1_q;  wsel[2] = W_FULL; end
      SEC_RED_BLU: begin wsel[0] = W_FULL; wsel[2] = wx1_q;  end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      p_d[i] = $signed({{(PW-PctW){1'b0}}, val1_q}) *
               $signed({{(PW-WW){wsel[i][WW-1]}}, wsel[i]});
    end
  end

  // 255*P >> 7, then divide by 5^7; the sign bit wins over the quotient
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pn[i]    = p2_q[i][23:0];
      n255[i]  = {pn[i], 8'd0} - {8'd0, pn[i]};
      prod[i]  = {26'd0, n255[i][31:7]} * {25'd0, DIV5P7_MUL};
      quo_d[i] = prod[i][DIV5P7_SHIFT +: 9];
      ch_d[i]  = neg3_q[i] ? '0 : (quo3_q[i][8] ? '1 : quo3_q[i][7:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sec1_q <= in_item_i.sector;
      val1_q <= in_item_i.val;
      wx1_q  <= wx_full[WW-1:0];
      wz1_q  <= m0_full[WW-1:0];
      for (int i = 0; i < 3; i++) begin
        p2_q[i]   <= p_d[i];
        neg3_q[i] <= p2_q[i][PW-1];
        quo3_q[i] <= quo_d[i];
        ch4_q[i]  <= ch_d[i];
      end
    end
  end

endmodule

### verif/hsv_to_rgb_converter_tb.sv
// Self-checking stream testbench for the HSV to RGB converter with its own predictor.
module hsv_to_rgb_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import h2r_pkg::*;

  localparam int unsigned NumRandom  = 1030;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldOffLen = 200;
  localparam int unsigned DrainWait  = 16;
  localparam longint      Denom      = 64'd10000000;

  // One colour going in and one coming out
  typedef struct packed {
    logic [PctW-1:0] val;
    logic [PctW-1:0] sat;
    logic [HueW-1:0] hue;
  } hsv_t;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } rgb_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;       // hue[11:0], saturation[18:12], brightness[25:19]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;            // red[7:0], green[15:8], blue[23:16]

  hsv_t pending_hsv[$];                 // colours not yet offered to the block
  rgb_t expected_rgb[$];                // predicted colours, oldest first
  hsv_t next_px;
  rgb_t got_rgb;
  rgb_t want_rgb;

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned hold_off_left = 0;
  logic        in_taken = 1'b0;
  logic        src_idle_on = 1'b0;
  logic        sink_idle_on = 1'b0;
  logic        hold_off_req = 1'b0;
  logic        hold_off_seen = 1'b0;

  hsv_to_rgb_converter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Clamp one channel: negative sums go to zero, overflow sticks at full scale.
  function automatic logic [ChanW-1:0] chan_level(longint part, longint offset);
    longint num;
    longint q;
    num = 255 * (part + offset);
    if (num < 0) return '0;
    q = num / Denom;
    if (q > 255) q = 255;
    return q[ChanW-1:0];
  endfunction

  // Work everything over the common denominator 10^7 so that nothing rounds
  // except the hue position and the final divide.
  function automatic rgb_t rgb_of_hsv(hsv_t px);
    longint  h, s, v, t, d, c, x, m, rp, gp, bp;
    sector_e sec;
    rgb_t    res;
    h = px.hue;
    s = px.sat;
    v = px.val;
    t = ((h * 5) / 3) % 2000;
    d = t - 1000;
    if (d < 0) d = -d;
    c = v * s * 1000;
    x = v * s * (1000 - d);
    m = v * 1000 * (100 - s);
    if (h < 600)       sec = SEC_RED_GRN;
    else if (h < 1200) sec = SEC_GRN_RED;
    else if (h < 1800) sec = SEC_GRN_BLU;
    else if (h < 2400) sec = SEC_BLU_GRN;
    else if (h < 3000) sec = SEC_BLU_RED;
    else               sec = SEC_RED_BLU;
    rp = 0;
    gp = 0;
    bp = 0;
    case (sec)
      SEC_RED_GRN: begin rp = c; gp = x; end
      SEC_GRN_RED: begin rp = x; gp = c; end
      SEC_GRN_BLU: begin gp = c; bp = x; end
      SEC_BLU_GRN: begin gp = x; bp = c; end
      SEC_BLU_RED: begin rp = x; bp = c; end
      default:     begin rp = c; bp = x; end
    endcase
    res.red   = chan_level(rp, m);
    res.green = chan_level(gp, m);
    res.blue  = chan_level(bp, m);
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  function automatic hsv_t mk_hsv(int unsigned h, int unsigned s, int unsigned v);
    hsv_t px;
    px.hue = h[HueW-1:0];
    px.sat = s[PctW-1:0];
    px.val = v[PctW-1:0];
    return px;
  endfunction

  // Random colour: mostly legal ranges, some sector edges, some full field range.
  function automatic hsv_t rand_hsv();
    int unsigned r;
    int unsigned h;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      h = 600 * $urandom_range(1, 6);
      h = h - 1 + $urandom_range(0, 2);
      return mk_hsv(h, $urandom_range(0, 100), $urandom_range(0, 100));
    end
    if (r < 82) return mk_hsv($urandom_range(0, 3600), $urandom_range(0, 100),
                              $urandom_range(0, 100));
    return mk_hsv($urandom_range(0, 4095), $urandom_range(0, 127), $urandom_range(0, 127));
  endfunction

  task automatic flag_mismatch(string msg);
    $display("mismatch @%0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // Source: advance to the next word once the current one is taken, or idle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (src_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (pending_hsv.size() > 0) begin
        next_px = pending_hsv.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, next_px.val, next_px.sat, next_px.hue};
        if (src_idle_on && $urandom_range(0, 2) == 0) src_gap <= gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink: random stalls, plus one long hold-off so the queue fills and
  // the block drops s_axis_tready.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off_req && !hold_off_seen) begin
      hold_off_seen <= 1'b1;
      hold_off_left <= HoldOffLen;
      m_axis_tready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
      sink_gap <= gap_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: predict on every accepted input word, check every output word.
  always @(posedge clk_i) begin
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_rgb.push_back(rgb_of_hsv(s_axis_tdata[HueW+2*PctW-1:0]));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_rgb = m_axis_tdata;
      if (expected_rgb.size() == 0) begin
        flag_mismatch($sformatf("unexpected word %h", m_axis_tdata));
      end else begin
        want_rgb = expected_rgb.pop_front();
        if (got_rgb.red !== want_rgb.red)
          flag_mismatch($sformatf("red got %0d want %0d", got_rgb.red, want_rgb.red));
        if (got_rgb.green !== want_rgb.green)
          flag_mismatch($sformatf("green got %0d want %0d", got_rgb.green, want_rgb.green));
        if (got_rgb.blue !== want_rgb.blue)
          flag_mismatch($sformatf("blue got %0d want %0d", got_rgb.blue, want_rgb.blue));
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // Directed words: sector edges, field extremes, negative offset
    // (saturation above 100) and clipping (brightness above 100).
    pending_hsv.push_back(mk_hsv(0, 0, 0));
    pending_hsv.push_back(mk_hsv(0, 100, 100));
    pending_hsv.push_back(mk_hsv(599, 100, 100));
    pending_hsv.push_back(mk_hsv(600, 100, 100));
    pending_hsv.push_back(mk_hsv(1199, 100, 100));
    pending_hsv.push_back(mk_hsv(1200, 100, 100));
    pending_hsv.push_back(mk_hsv(1799, 100, 100));
    pending_hsv.push_back(mk_hsv(1800, 75, 100));
    pending_hsv.push_back(mk_hsv(2399, 100, 60));
    pending_hsv.push_back(mk_hsv(2400, 50, 50));
    pending_hsv.push_back(mk_hsv(2999, 100, 100));
    pending_hsv.push_back(mk_hsv(3000, 100, 100));
    pending_hsv.push_back(mk_hsv(3600, 100, 100));
    pending_hsv.push_back(mk_hsv(3601, 80, 90));
    pending_hsv.push_back(mk_hsv(4095, 100, 100));
    pending_hsv.push_back(mk_hsv(4095, 127, 127));
    pending_hsv.push_back(mk_hsv(900, 127, 100));
    pending_hsv.push_back(mk_hsv(2100, 101, 50));
    pending_hsv.push_back(mk_hsv(300, 0, 127));
    pending_hsv.push_back(mk_hsv(1500, 100, 127));
    pending_hsv.push_back(mk_hsv(2700, 50, 101));
    pending_hsv.push_back(mk_hsv(3300, 127, 0));
    pending_hsv.push_back(mk_hsv(1, 1, 1));
    for (int unsigned i = 0; i < NumRandom; i++) pending_hsv.push_back(rand_hsv());

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part runs back to back, then idling on both sides.
    while (pending_hsv.size() > NumRandom) @(posedge clk_i);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    while (pending_hsv.size() > NumRandom / 2) @(posedge clk_i);
    hold_off_req = 1'b1;
    // Idling goes on to the quarter mark, then a stretch with no idling at all.
    while (pending_hsv.size() > NumRandom / 4) @(posedge clk_i);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    while (pending_hsv.size() > NumRandom / 8) @(posedge clk_i);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;

    // Drain: all words offered and taken, all results back, then settle.
    while (pending_hsv.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_rgb.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
